FILE: hw/rtl/ctpt_pkg.sv
`timescale 1ns / 1ps
// Package for the parent transform composition block: fixed-point constants,
// the CORDIC arctangent table and the types shared between the modules.
// Depends on nothing; every other file of the block but ctpt_if.sv uses it.
package ctpt_pkg;

	// Angles in Q16.16 degrees
	localparam logic [32:0] TURN    = 33'd23592960;
	localparam logic [32:0] HALF    = 33'd11796480;
	localparam logic [32:0] QUARTER = 33'd5898240;
	// Offset that lifts any negative 32-bit angle to a non-negative value
	// while keeping it congruent modulo one turn (92 turns).
	localparam logic [32:0] ANGLE_OFFSET = 33'd2170552320;

	// CORDIC gain in Q0.32, split into halves for the partial products
	localparam logic [31:0] GAIN    = 32'h9B74EDA8;
	localparam logic [15:0] GAIN_HI = GAIN[31:16];
	localparam logic [15:0] GAIN_LO = GAIN[15:0];

	localparam int TABLE_LEN    = 30;
	localparam int CORDIC_STEPS = 16;
	localparam int STEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

	// Datapath widths: vector with 16 guard bits, residual angle in Q24 degrees
	localparam int XY_W = 50;
	localparam int Z_W  = 33;

	localparam int Q_DEPTH = 4;
	localparam int QP_W    = $clog2(Q_DEPTH);

	// atan(2^-i) in degrees with 24 fraction bits
	function automatic logic signed [Z_W-1:0] atan_q24(input logic [4:0] idx);
		logic signed [Z_W-1:0] r;
		unique case (idx)
			5'd0:  r = 33'sd754974720;
			5'd1:  r = 33'sd445687602;
			5'd2:  r = 33'sd235489088;
			5'd3:  r = 33'sd119537938;
			5'd4:  r = 33'sd60000934;
			5'd5:  r = 33'sd30029717;
			5'd6:  r = 33'sd15018523;
			5'd7:  r = 33'sd7509720;
			5'd8:  r = 33'sd3754917;
			5'd9:  r = 33'sd1877466;
			5'd10: r = 33'sd938734;
			5'd11: r = 33'sd469367;
			5'd12: r = 33'sd234684;
			5'd13: r = 33'sd117342;
			5'd14: r = 33'sd58671;
			5'd15: r = 33'sd29335;
			5'd16: r = 33'sd14668;
			5'd17: r = 33'sd7334;
			5'd18: r = 33'sd3667;
			5'd19: r = 33'sd1833;
			5'd20: r = 33'sd917;
			5'd21: r = 33'sd458;
			5'd22: r = 33'sd229;
			5'd23: r = 33'sd115;
			5'd24: r = 33'sd57;
			5'd25: r = 33'sd29;
			5'd26: r = 33'sd14;
			5'd27: r = 33'sd7;
			5'd28: r = 33'sd4;
			5'd29: r = 33'sd2;
			default: r = '0;
		endcase
		return r;
	endfunction

	// One classified item waiting for the rotation unit
	typedef struct packed {
		logic signed [32:0]     x;
		logic signed [32:0]     y;
		logic signed [Z_W-1:0]  z;
		logic signed [31:0]     px;
		logic signed [31:0]     py;
		logic signed [15:0]     sx;
		logic signed [15:0]     sy;
		logic signed [31:0]     wa;
	} q_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

FILE: hw/rtl/ctpt_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the parent transform composition block: input items,
// results and the configuration write channel. No package dependencies.
interface ctpt_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] local_x;
	logic signed [31:0] local_y;
	logic signed [15:0] local_scale_x;
	logic signed [15:0] local_scale_y;
	logic signed [31:0] local_angle;
	logic signed [31:0] parent_x;
	logic signed [31:0] parent_y;
	logic signed [15:0] parent_scale_x;
	logic signed [15:0] parent_scale_y;
	logic signed [31:0] parent_angle;
	logic               has_parent;

	modport source (output valid, local_x, local_y, local_scale_x, local_scale_y,
		local_angle, parent_x, parent_y, parent_scale_x, parent_scale_y,
		parent_angle, has_parent, input ready);
	modport sink (input valid, local_x, local_y, local_scale_x, local_scale_y,
		local_angle, parent_x, parent_y, parent_scale_x, parent_scale_y,
		parent_angle, has_parent, output ready);
endinterface

interface ctpt_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] world_x;
	logic signed [31:0] world_y;
	logic signed [15:0] world_scale_x;
	logic signed [15:0] world_scale_y;
	logic signed [31:0] world_angle;

	modport source (output valid, world_x, world_y, world_scale_x, world_scale_y,
		world_angle, input ready);
	modport sink (input valid, world_x, world_y, world_scale_x, world_scale_y,
		world_angle, output ready);
endinterface

interface ctpt_cfg_if;
	logic valid;
	logic ready;
	logic follow_parent_scale;

	modport source (output valid, follow_parent_scale, input ready);
	modport sink (input valid, follow_parent_scale, output ready);
endinterface

FILE: hw/rtl/compose_parent_transform_2d_core.sv
`timescale 1ns / 1ps
// Composes a scene node's local 2D transform with its parent's world transform,
// one result transaction per input transaction, sustaining one transaction per
// clock cycle when the result side keeps up. An item passes 25 registers, the
// first loaded at the edge that accepts it: five front stages (angle sum, scale
// products and reduction of the parent angle modulo 360 degrees, two
// compare-subtract steps in each stage after the first), the four-entry queue,
// two gain pre-scaling stages, one stage for each of the 16 CORDIC iterations
// and the output register. Positions and angles are signed Q16.16, scales
// signed Q8.8; all results saturate. Without a parent the local values pass
// through unchanged. The follow_parent_scale register resets to 1 and is
// written through the configuration channel, which is always ready; write it
// only while idle.
// Depends on ctpt_pkg, ctpt_if.sv, ctpt_front, ctpt_queue and ctpt_back.
module compose_parent_transform_2d_core (
	input  logic        clk,
	input  logic        arst_n,
	ctpt_cfg_if.sink    cfg,
	ctpt_in_if.sink     node,
	ctpt_out_if.source  world
);

	// The front end and the rotation unit meet at a short queue, so a stall
	// on the result side only stops the front once the queue has filled.
	logic              push, pop;
	ctpt_pkg::q_item_t push_data, pop_data;
	ctpt_pkg::q_stat_t q_stat;

	ctpt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.node      (node),
		.push      (push),
		.push_data (push_data),
		.full      (q_stat.full)
	);

	ctpt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (q_stat)
	);

	ctpt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_data (pop_data),
		.empty    (q_stat.empty),
		.pop      (pop),
		.world    (world)
	);

	// The queue is never written while full.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_stat.full))
		else $error("queue written while full");

	// The rotation unit never takes an item from an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && q_stat.empty))
		else $error("queue read while empty");

	// The input side only stalls behind a full queue.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!node.ready |-> q_stat.full)
		else $error("input stalled with room in the queue");

endmodule

FILE: hw/rtl/ctpt_front.sv
`timescale 1ns / 1ps
// Front end: accepts items, forms the angle sum and scale products, reduces
// the parent angle modulo one turn and folds it into the CORDIC range.
// Depends on ctpt_pkg and the channel interfaces in ctpt_if.sv.
module ctpt_front (
	input  logic              clk,
	input  logic              arst_n,
	ctpt_cfg_if.sink          cfg,
	ctpt_in_if.sink           node,
	output logic              push,
	output ctpt_pkg::q_item_t push_data,
	input  logic              full
);

	typedef struct packed {
		logic signed [32:0] x;
		logic signed [32:0] y;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [15:0] lsx;
		logic signed [15:0] lsy;
		logic signed [31:0] prx;
		logic signed [31:0] pry;
		logic               use_prod;
		logic signed [31:0] wa;
		logic [32:0]        u;
	} s1_t;

	typedef struct packed {
		logic signed [32:0] x;
		logic signed [32:0] y;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		logic signed [31:0] wa;
		logic [32:0]        u;
	} red_t;

	function automatic logic [32:0] red_step(input logic [32:0] u, input int unsigned k);
		logic [32:0] t;
		t = ctpt_pkg::TURN << k;
		return (u >= t) ? (u - t) : u;
	endfunction

	function automatic logic signed [15:0] scale_round(input logic signed [31:0] p);
		logic signed [32:0] t;
		t = ($signed({p[31], p}) + 33'sd128) >>> 8;
		if (t[32:15] == {18{t[32]}})
			return t[15:0];
		return t[32] ? 16'sh8000 : 16'sh7fff;
	endfunction

	logic        follow_q;
	logic        adv;
	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	s1_t         s1_d, fr_s1;
	red_t        s2_d, s3_d, s4_d, s5_d, fr_s2, fr_s3, fr_s4, fr_s5;
	logic signed [32:0] asum;
	logic [32:0] m_lo;
	logic signed [26:0] ms, mf;
	logic        flip;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			follow_q <= 1'b1;
		end else if (cfg.valid && cfg.ready) begin
			follow_q <= cfg.follow_parent_scale;
		end
	end

	assign adv        = !vld_s5 || !full;
	assign node.ready = adv;
	assign push       = vld_s5 && !full;

	// Stage 1 inputs: sums and products, a pass-through item gets a null vector
	always_comb begin
		asum        = $signed({node.local_angle[31], node.local_angle})
			+ $signed({node.parent_angle[31], node.parent_angle});
		s1_d.x      = node.has_parent ? 33'(node.local_x) : '0;
		s1_d.y      = node.has_parent ? 33'(node.local_y) : '0;
		s1_d.px     = node.has_parent ? node.parent_x : node.local_x;
		s1_d.py     = node.has_parent ? node.parent_y : node.local_y;
		s1_d.lsx    = node.local_scale_x;
		s1_d.lsy    = node.local_scale_y;
		s1_d.prx    = 32'(node.local_scale_x * node.parent_scale_x);
		s1_d.pry    = 32'(node.local_scale_y * node.parent_scale_y);
		s1_d.use_prod = node.has_parent && follow_q;
		if (!node.has_parent)
			s1_d.wa = node.local_angle;
		else if (asum[32] != asum[31])
			s1_d.wa = asum[32] ? 32'sh80000000 : 32'sh7fffffff;
		else
			s1_d.wa = asum[31:0];
		s1_d.u = node.parent_angle[31]
			? ({node.parent_angle[31], node.parent_angle} + ctpt_pkg::ANGLE_OFFSET)
			: {1'b0, node.parent_angle};
	end

	always_comb begin
		s2_d.x  = fr_s1.x;
		s2_d.y  = fr_s1.y;
		s2_d.px = fr_s1.px;
		s2_d.py = fr_s1.py;
		s2_d.sx = fr_s1.use_prod ? scale_round(fr_s1.prx) : fr_s1.lsx;
		s2_d.sy = fr_s1.use_prod ? scale_round(fr_s1.pry) : fr_s1.lsy;
		s2_d.wa = fr_s1.wa;
		s2_d.u  = red_step(red_step(fr_s1.u, 7), 6);
	end

	// Two restoring reduction steps per stage
	always_comb begin
		s3_d   = fr_s2;
		s3_d.u = red_step(red_step(fr_s2.u, 5), 4);
		s4_d   = fr_s3;
		s4_d.u = red_step(red_step(fr_s3.u, 3), 2);
		s5_d   = fr_s4;
		s5_d.u = red_step(red_step(fr_s4.u, 1), 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= node.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fr_s1 <= s1_d;
			fr_s2 <= s2_d;
			fr_s3 <= s3_d;
			fr_s4 <= s4_d;
			fr_s5 <= s5_d;
		end
	end

	// Map to [-180,180), then fold into [-90,90] negating the vector
	always_comb begin
		m_lo = fr_s5.u;
		ms   = (m_lo >= ctpt_pkg::HALF) ? $signed(27'(m_lo) - 27'(ctpt_pkg::TURN))
			: $signed(27'(m_lo));
		flip = 1'b0;
		mf   = ms;
		if (ms > $signed(27'(ctpt_pkg::QUARTER))) begin
			flip = 1'b1;
			mf   = ms - $signed(27'(ctpt_pkg::HALF));
		end else if (ms < -$signed(27'(ctpt_pkg::QUARTER))) begin
			flip = 1'b1;
			mf   = ms + $signed(27'(ctpt_pkg::HALF));
		end
		push_data.x  = flip ? -fr_s5.x : fr_s5.x;
		push_data.y  = flip ? -fr_s5.y : fr_s5.y;
		// The folded angle stays within 90 degrees, so 25 bits hold it
		push_data.z  = $signed({mf[24:0], 8'd0});
		push_data.px = fr_s5.px;
		push_data.py = fr_s5.py;
		push_data.sx = fr_s5.sx;
		push_data.sy = fr_s5.sy;
		push_data.wa = fr_s5.wa;
	end

endmodule

FILE: hw/rtl/ctpt_queue.sv
`timescale 1ns / 1ps
// Short first-in first-out queue between the front end and the rotation unit.
// Depends on ctpt_pkg for the item type and depth.
module ctpt_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ctpt_pkg::q_item_t push_data,
	input  logic              pop,
	output ctpt_pkg::q_item_t pop_data,
	output ctpt_pkg::q_stat_t stat
);

	ctpt_pkg::q_item_t           mem_q [ctpt_pkg::Q_DEPTH];
	logic [ctpt_pkg::QP_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [ctpt_pkg::QP_W:0]     count_q;

	assign stat.full  = (count_q == (ctpt_pkg::QP_W + 1)'(ctpt_pkg::Q_DEPTH));
	assign stat.empty = (count_q == '0);
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

FILE: hw/rtl/ctpt_back.sv
`timescale 1ns / 1ps
// Back end: gain pre-scaling, the pipelined CORDIC rotation, rounding, the
// parent offset and the output register. Depends on ctpt_pkg and ctpt_if.sv.
module ctpt_back (
	input  logic              clk,
	input  logic              arst_n,
	input  ctpt_pkg::q_item_t pop_data,
	input  logic              empty,
	output logic              pop,
	ctpt_out_if.source        world
);

	localparam int N = ctpt_pkg::STEPS;

	typedef struct packed {
		logic signed [ctpt_pkg::XY_W-1:0] xh;
		logic signed [ctpt_pkg::XY_W-1:0] xl;
		logic signed [ctpt_pkg::XY_W-1:0] yh;
		logic signed [ctpt_pkg::XY_W-1:0] yl;
		logic signed [ctpt_pkg::Z_W-1:0]  z;
		logic signed [31:0]               px;
		logic signed [31:0]               py;
		logic signed [15:0]               sx;
		logic signed [15:0]               sy;
		logic signed [31:0]               wa;
	} pp_t;

	typedef struct packed {
		logic signed [ctpt_pkg::XY_W-1:0] x;
		logic signed [ctpt_pkg::XY_W-1:0] y;
		logic signed [ctpt_pkg::Z_W-1:0]  z;
		logic signed [31:0]               px;
		logic signed [31:0]               py;
		logic signed [15:0]               sx;
		logic signed [15:0]               sy;
		logic signed [31:0]               wa;
	} rot_t;

	typedef struct packed {
		logic signed [31:0] wx;
		logic signed [31:0] wy;
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		logic signed [31:0] wa;
	} res_t;

	localparam logic signed [ctpt_pkg::XY_W-1:0] G_HI = ctpt_pkg::XY_W'(ctpt_pkg::GAIN_HI);
	localparam logic signed [ctpt_pkg::XY_W-1:0] G_LO = ctpt_pkg::XY_W'(ctpt_pkg::GAIN_LO);
	localparam logic signed [ctpt_pkg::XY_W-1:0] RND  = ctpt_pkg::XY_W'(32768);

	function automatic rot_t cordic_step(input rot_t a, input logic [4:0] i);
		rot_t r;
		logic signed [ctpt_pkg::XY_W-1:0] dx, dy;
		r  = a;
		dx = a.y >>> i;
		dy = a.x >>> i;
		if (a.z >= 0) begin
			r.x = a.x - dx;
			r.y = a.y + dy;
			r.z = a.z - ctpt_pkg::atan_q24(i);
		end else begin
			r.x = a.x + dx;
			r.y = a.y - dy;
			r.z = a.z + ctpt_pkg::atan_q24(i);
		end
		return r;
	endfunction

	function automatic logic signed [31:0] place(input logic signed [ctpt_pkg::XY_W-1:0] v,
		input logic signed [31:0] p);
		logic signed [ctpt_pkg::XY_W-1:0] r;
		logic signed [34:0] s;
		r = (v + RND) >>> 16;
		s = $signed(r[34:0]) + $signed({{3{p[31]}}, p});
		if (s[34:31] == {4{s[34]}})
			return s[31:0];
		return s[34] ? 32'sh80000000 : 32'sh7fffffff;
	endfunction

	logic                 adv;
	logic                 vld_s1;
	logic [N:0]           rot_vld_s;
	logic                 out_vld_q;
	pp_t                  pp_s1, pp_d;
	rot_t                 rot_s [N+1];
	rot_t                 rot_d;
	res_t                 out_q, out_d;
	logic signed [ctpt_pkg::XY_W-1:0] x_ext, y_ext;

	assign adv = !out_vld_q || world.ready;
	assign pop = adv && !empty;

	always_comb begin
		x_ext   = ctpt_pkg::XY_W'(pop_data.x);
		y_ext   = ctpt_pkg::XY_W'(pop_data.y);
		pp_d.xh = x_ext * G_HI;
		pp_d.xl = x_ext * G_LO;
		pp_d.yh = y_ext * G_HI;
		pp_d.yl = y_ext * G_LO;
		pp_d.z  = pop_data.z;
		pp_d.px = pop_data.px;
		pp_d.py = pop_data.py;
		pp_d.sx = pop_data.sx;
		pp_d.sy = pop_data.sy;
		pp_d.wa = pop_data.wa;
	end

	// x * gain / 2^16 rounded: high product plus rounded carry from the low one
	always_comb begin
		rot_d.x  = pp_s1.xh + ((pp_s1.xl + RND) >>> 16);
		rot_d.y  = pp_s1.yh + ((pp_s1.yl + RND) >>> 16);
		rot_d.z  = pp_s1.z;
		rot_d.px = pp_s1.px;
		rot_d.py = pp_s1.py;
		rot_d.sx = pp_s1.sx;
		rot_d.sy = pp_s1.sy;
		rot_d.wa = pp_s1.wa;
	end

	always_comb begin
		out_d.wx = place(rot_s[N].x, rot_s[N].px);
		out_d.wy = place(rot_s[N].y, rot_s[N].py);
		out_d.sx = rot_s[N].sx;
		out_d.sy = rot_s[N].sy;
		out_d.wa = rot_s[N].wa;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			rot_vld_s <= '0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1    <= !empty;
			rot_vld_s <= {rot_vld_s[N-1:0], vld_s1};
			out_vld_q <= rot_vld_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pp_s1    <= pp_d;
			rot_s[0] <= rot_d;
			out_q    <= out_d;
		end
	end

	genvar g;
	for (g = 0; g < N; g++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (adv)
				rot_s[g+1] <= cordic_step(rot_s[g], 5'(g));
		end
	end

	assign world.valid         = out_vld_q;
	assign world.world_x       = out_q.wx;
	assign world.world_y       = out_q.wy;
	assign world.world_scale_x = out_q.sx;
	assign world.world_scale_y = out_q.sy;
	assign world.world_angle   = out_q.wa;

endmodule
